FILE: src/ttpl_pkg.sv
// Shared constants, types and codes of the tabular turn policy learner.
package ttpl_pkg;

  // Default configuration of the learner
  localparam int BINS_PER_SENSOR = 10;
  localparam int ACTIONS         = 5;
  localparam int TURN_STEP       = 30;

  // Word field widths
  localparam int RANGE_W  = 10;
  localparam int MOTION_W = 2;
  localparam int VALUE_W  = 8;

  // Range clamp window in cm
  localparam int RANGE_LOW  = 30;
  localparam int RANGE_HIGH = 130;
  localparam int RANGE_SPAN = RANGE_HIGH - RANGE_LOW;

  // Value table limits
  localparam int VALUE_FLOOR   = -80;
  localparam int VALUE_LIMIT   = 80;
  localparam int VALUE_DISCARD = -81;
  localparam int SMALL_LIMIT   = 5;

  // Start values: INIT_LOW for the first action up to INIT_LOW + INIT_SPAN for the last
  localparam int INIT_LOW  = -60;
  localparam int INIT_SPAN = 120;

  // Most results one input word can cause
  localparam int RESULT_CAP = 3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [MOTION_W-1:0] {
    MOT_WALK       = 2'd0,
    MOT_WALK_STAND = 2'd1,
    MOT_TURN       = 2'd2,
    MOT_STAND      = 2'd3
  } motion_e;

  typedef enum logic [1:0] {
    PH_WALK   = 2'd0,
    PH_TURN   = 2'd1,
    PH_REWARD = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_EMIT,
    ST_RREAD,
    ST_RWRITE
  } state_e;

endpackage

FILE: src/ttpl_in_if.sv
// Input channel: obstacle sensor bit and two ultrasonic ranges.
interface ttpl_in_if;
  logic                         valid;
  logic                         ready;
  logic                         obstacle_clear;
  logic [ttpl_pkg::RANGE_W-1:0] range_left;
  logic [ttpl_pkg::RANGE_W-1:0] range_right;

  modport source (output valid, output obstacle_clear, output range_left,
                  output range_right, input ready);
  modport sink   (input valid, input obstacle_clear, input range_left,
                  input range_right, output ready);
endinterface

FILE: src/ttpl_out_if.sv
// Output channel: motion code, turn angle, table update flag, last flag.
interface ttpl_out_if;
  logic              valid;
  logic              ready;
  ttpl_pkg::motion_e motion;
  ttpl_pkg::value_t  turn_degrees;
  logic              table_changed;
  logic              last;

  modport source (output valid, output motion, output turn_degrees,
                  output table_changed, output last, input ready);
  modport sink   (input valid, input motion, input turn_degrees,
                  input table_changed, input last, output ready);
endinterface

FILE: src/ttpl_binner.sv
// Range binner: clamps a distance to the window and maps it to a bin index.
module ttpl_binner #(
  parameter int BinsPerSensor = ttpl_pkg::BINS_PER_SENSOR,
  localparam int BinW         = $clog2(BinsPerSensor)
) (
  input  logic [ttpl_pkg::RANGE_W-1:0] range_i,
  output logic [BinW-1:0]              bin_o
);

  // Threshold k is the smallest range that lands in bin k; the clamp falls out
  // because the first threshold lies above the low edge and the last below the high.
  logic [BinsPerSensor-1:1] above;

  for (genvar k = 1; k < BinsPerSensor; k++) begin : g_thr
    localparam int Thr = ttpl_pkg::RANGE_LOW
                         + (ttpl_pkg::RANGE_SPAN * k + BinsPerSensor - 1) / BinsPerSensor;
    assign above[k] = range_i >= ttpl_pkg::RANGE_W'(Thr);
  end

  // Thermometer code to index
  always_comb begin
    bin_o = '0;
    for (int k = 1; k < BinsPerSensor; k++) begin
      if (above[k]) begin
        bin_o = BinW'(k);
      end
    end
  end

endmodule

FILE: src/tabular_turn_policy_learner_unit.sv
// Top level of the tabular turn policy learner: phase control and value table.
//
// Usage: every word on in_i is one pass of the walk / turn / reward loop. A
// walk word gives one result (walk, or walk then stand when an obstacle is
// seen, which arms the turn phase). A turn word bins both ranges, scans the
// stored values of all actions for that bin pair and gives one to three turn
// step results. A reward word gives one stand result and, with the obstacle
// still present, rescales the chosen table entry. The final result of each
// word carries last = 1.
// Flow: a walk word goes from acceptance through ST_WALK to its result. A turn
// word scans the stored values in ST_SCAN before its first result, reading the
// single read port of the table memory once per action; ST_EMIT then gives the
// steps one after another. A reward word reads the entry in ST_RREAD, then
// modifies and writes it back in ST_RWRITE. in_i.ready is high only while no
// word is being worked on, which includes the cycle in which the final result
// appears.
// Reset: a clearing pass writes the start value of each action into the table;
// in_i.ready stays low.
// Stall: a result waits in the output register while out_o.ready is low and
// the block holds its work until the register frees up.
module tabular_turn_policy_learner_unit #(
  parameter int BinsPerSensor = ttpl_pkg::BINS_PER_SENSOR,
  parameter int Actions       = ttpl_pkg::ACTIONS,
  parameter int TurnStep      = ttpl_pkg::TURN_STEP
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ttpl_in_if.sink           in_i,
  ttpl_out_if.source        out_o
);

  localparam int Cells     = BinsPerSensor * BinsPerSensor;
  localparam int Depth     = Actions * Cells;
  localparam int BinW      = $clog2(BinsPerSensor);
  localparam int CellW     = $clog2(Cells);
  localparam int ActW      = $clog2(Actions);
  localparam int ScanW     = $clog2(Actions + 1);
  localparam int AddrW     = $clog2(Depth);
  localparam int StepCntW  = $clog2(ttpl_pkg::RESULT_CAP);
  localparam int RwW       = ttpl_pkg::VALUE_W + 4;

  localparam ttpl_pkg::value_t StepV    = ttpl_pkg::value_t'(TurnStep);
  localparam ttpl_pkg::value_t NegStepV = ttpl_pkg::value_t'(-TurnStep);
  localparam ttpl_pkg::value_t FloorV   = ttpl_pkg::value_t'(ttpl_pkg::VALUE_FLOOR);
  localparam ttpl_pkg::value_t DiscardV = ttpl_pkg::value_t'(ttpl_pkg::VALUE_DISCARD);

  // Control state
  ttpl_pkg::state_e state_q, state_d;
  ttpl_pkg::phase_e phase_q, phase_d;
  logic [CellW-1:0]    cell_q, cell_d;
  logic [ActW-1:0]     act_q, act_d;
  logic [ActW-1:0]     init_act_q, init_act_d;
  logic [CellW-1:0]    init_cell_q, init_cell_d;
  logic [ScanW-1:0]    scan_cnt_q, scan_cnt_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [StepCntW-1:0] step_cnt_q, step_cnt_d;
  logic                out_vld_q, out_vld_d;

  // Payload state
  logic                obst_q, obst_d;
  ttpl_pkg::value_t    best_q, best_d;
  logic [ActW-1:0]     best_act_q, best_act_d;
  logic [ActW-1:0]     cmp_act_q, cmp_act_d;
  ttpl_pkg::motion_e   out_motion_q, out_motion_d;
  ttpl_pkg::value_t    out_deg_q, out_deg_d;
  logic                out_chg_q, out_chg_d;
  logic                out_last_q, out_last_d;

  // Table memory
  ttpl_pkg::value_t    value_mem_q [Depth];
  ttpl_pkg::value_t    rd_data_q;
  logic                mem_re;
  logic                mem_we;
  logic [AddrW-1:0]    mem_addr;
  ttpl_pkg::value_t    mem_wdata;
  logic [ActW-1:0]     addr_act;
  logic [CellW-1:0]    addr_cell;

  // Helpers
  ttpl_pkg::value_t    init_val [Actions];
  logic [BinW-1:0]     bin_l;
  logic [BinW-1:0]     bin_r;
  logic [CellW-1:0]    in_cell;
  logic                in_acc;
  logic                out_free;
  logic                init_last;
  logic                scan_done;
  logic                step_up;
  logic                step_dn;
  logic                emit_final;
  logic signed [RwW-1:0] rw_prod;
  logic signed [RwW-1:0] rw_scaled;
  ttpl_pkg::value_t    rw_val;

  // Start value of each action, worked out at elaboration
  for (genvar g = 0; g < Actions; g++) begin : g_init
    localparam int InitV = ttpl_pkg::INIT_LOW + (ttpl_pkg::INIT_SPAN * g) / (Actions - 1);
    assign init_val[g] = ttpl_pkg::value_t'(InitV);
  end

  // Range binning
  ttpl_binner #(.BinsPerSensor(BinsPerSensor)) u_bin_left (
    .range_i (in_i.range_left),
    .bin_o   (bin_l)
  );

  ttpl_binner #(.BinsPerSensor(BinsPerSensor)) u_bin_right (
    .range_i (in_i.range_right),
    .bin_o   (bin_r)
  );

  assign in_cell = CellW'(bin_l) * CellW'(BinsPerSensor) + CellW'(bin_r);

  // Handshake terms
  assign in_i.ready = (state_q == ttpl_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // Sequencing conditions
  assign init_last  = (init_act_q == ActW'(Actions - 1)) && (init_cell_q == CellW'(Cells - 1));
  assign scan_done  = cmp_vld_q && (cmp_act_q == ActW'(Actions - 1));
  assign step_up    = (best_q > StepV) && (step_cnt_q < StepCntW'(ttpl_pkg::RESULT_CAP - 1));
  assign step_dn    = (best_q <= 0) && (best_q < NegStepV)
                      && (step_cnt_q < StepCntW'(ttpl_pkg::RESULT_CAP - 1));
  assign emit_final = !step_up && !step_dn;

  // Reward update: scale by 10/8 toward zero, discard out-of-range or small values
  always_comb begin
    rw_prod   = $signed({{(RwW - ttpl_pkg::VALUE_W){rd_data_q[ttpl_pkg::VALUE_W-1]}}, rd_data_q})
                * RwW'(signed'(10));
    rw_scaled = (rw_prod < 0) ? ((rw_prod + RwW'(signed'(7))) >>> 3) : (rw_prod >>> 3);
    if ((rw_scaled > RwW'(signed'(ttpl_pkg::VALUE_LIMIT)))
        || (rw_scaled < RwW'(signed'(-ttpl_pkg::VALUE_LIMIT)))
        || ((rw_scaled > RwW'(signed'(-ttpl_pkg::SMALL_LIMIT)))
            && (rw_scaled < RwW'(signed'(ttpl_pkg::SMALL_LIMIT))))) begin
      rw_val = DiscardV;
    end else begin
      rw_val = ttpl_pkg::value_t'(rw_scaled);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttpl_pkg::ST_INIT: begin
        if (init_last) state_d = ttpl_pkg::ST_IDLE;
      end
      ttpl_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (phase_q)
            ttpl_pkg::PH_TURN:   state_d = ttpl_pkg::ST_SCAN;
            ttpl_pkg::PH_REWARD: state_d = ttpl_pkg::ST_RREAD;
            default:             state_d = ttpl_pkg::ST_WALK;
          endcase
        end
      end
      ttpl_pkg::ST_WALK: begin
        if (out_free) state_d = ttpl_pkg::ST_IDLE;
      end
      ttpl_pkg::ST_SCAN: begin
        if (scan_done) state_d = ttpl_pkg::ST_EMIT;
      end
      ttpl_pkg::ST_EMIT: begin
        if (out_free && emit_final) state_d = ttpl_pkg::ST_IDLE;
      end
      ttpl_pkg::ST_RREAD: begin
        state_d = ttpl_pkg::ST_RWRITE;
      end
      ttpl_pkg::ST_RWRITE: begin
        if (out_free) state_d = ttpl_pkg::ST_IDLE;
      end
      default: state_d = ttpl_pkg::ST_IDLE;
    endcase
  end

  // Table address: sweep counters, scan counter or chosen entry
  always_comb begin
    case (state_q)
      ttpl_pkg::ST_INIT: begin
        addr_act  = init_act_q;
        addr_cell = init_cell_q;
      end
      ttpl_pkg::ST_SCAN: begin
        addr_act  = scan_cnt_q[ActW-1:0];
        addr_cell = cell_q;
      end
      default: begin
        addr_act  = act_q;
        addr_cell = cell_q;
      end
    endcase
  end

  assign mem_addr = AddrW'(addr_act) * AddrW'(Cells) + AddrW'(addr_cell);

  // Datapath and outputs
  always_comb begin
    phase_d      = phase_q;
    cell_d       = cell_q;
    act_d        = act_q;
    init_act_d   = init_act_q;
    init_cell_d  = init_cell_q;
    scan_cnt_d   = scan_cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_act_d    = cmp_act_q;
    step_cnt_d   = step_cnt_q;
    obst_d       = obst_q;
    best_d       = best_q;
    best_act_d   = best_act_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_motion_d = out_motion_q;
    out_deg_d    = out_deg_q;
    out_chg_d    = out_chg_q;
    out_last_d   = out_last_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = rw_val;

    case (state_q)
      // clearing pass: start value of each action into every cell
      ttpl_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = init_val[init_act_q];
        if (init_cell_q == CellW'(Cells - 1)) begin
          init_cell_d = '0;
          init_act_d  = init_act_q + 1'b1;
        end else begin
          init_cell_d = init_cell_q + 1'b1;
        end
      end

      // take a word and set up its pass
      ttpl_pkg::ST_IDLE: begin
        if (in_acc) begin
          obst_d     = !in_i.obstacle_clear;
          best_d     = FloorV;
          best_act_d = '0;
          scan_cnt_d = '0;
          step_cnt_d = '0;
          if (phase_q == ttpl_pkg::PH_TURN) cell_d = in_cell;
        end
      end

      ttpl_pkg::ST_WALK: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_motion_d = obst_q ? ttpl_pkg::MOT_WALK_STAND : ttpl_pkg::MOT_WALK;
          out_deg_d    = '0;
          out_chg_d    = 1'b0;
          out_last_d   = 1'b1;
          phase_d      = obst_q ? ttpl_pkg::PH_TURN : ttpl_pkg::PH_WALK;
        end
      end

      // one read per action; compare the word read in the cycle before
      ttpl_pkg::ST_SCAN: begin
        if (scan_cnt_q < ScanW'(Actions)) begin
          mem_re     = 1'b1;
          scan_cnt_d = scan_cnt_q + 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_act_d  = scan_cnt_q[ActW-1:0];
        end
        if (cmp_vld_q && (rd_data_q > best_q)) begin
          best_d     = rd_data_q;
          best_act_d = cmp_act_q;
        end
      end

      // split the chosen value into turn steps
      ttpl_pkg::ST_EMIT: begin
        act_d = best_act_q;
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_motion_d = ttpl_pkg::MOT_TURN;
          out_chg_d    = 1'b0;
          if (step_up) begin
            out_deg_d  = StepV;
            out_last_d = 1'b0;
            best_d     = best_q - StepV;
            step_cnt_d = step_cnt_q + 1'b1;
          end else if (step_dn) begin
            out_deg_d  = NegStepV;
            out_last_d = 1'b0;
            best_d     = best_q + StepV;
            step_cnt_d = step_cnt_q + 1'b1;
          end else begin
            out_deg_d  = best_q;
            out_last_d = 1'b1;
            phase_d    = ttpl_pkg::PH_REWARD;
          end
        end
      end

      ttpl_pkg::ST_RREAD: begin
        mem_re = 1'b1;
      end

      // write back together with the result, once, when the obstacle is present
      ttpl_pkg::ST_RWRITE: begin
        if (out_free) begin
          mem_we       = obst_q;
          out_vld_d    = 1'b1;
          out_motion_d = ttpl_pkg::MOT_STAND;
          out_deg_d    = '0;
          out_chg_d    = obst_q;
          out_last_d   = 1'b1;
          phase_d      = ttpl_pkg::PH_WALK;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttpl_pkg::ST_INIT;
      phase_q     <= ttpl_pkg::PH_WALK;
      cell_q      <= '0;
      act_q       <= '0;
      init_act_q  <= '0;
      init_cell_q <= '0;
      scan_cnt_q  <= '0;
      cmp_vld_q   <= 1'b0;
      step_cnt_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cell_q      <= cell_d;
      act_q       <= act_d;
      init_act_q  <= init_act_d;
      init_cell_q <= init_cell_d;
      scan_cnt_q  <= scan_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      step_cnt_q  <= step_cnt_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    obst_q       <= obst_d;
    best_q       <= best_d;
    best_act_q   <= best_act_d;
    cmp_act_q    <= cmp_act_d;
    out_motion_q <= out_motion_d;
    out_deg_q    <= out_deg_d;
    out_chg_q    <= out_chg_d;
    out_last_q   <= out_last_d;
  end

  // Value table, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) value_mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_q <= value_mem_q[mem_addr];
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.motion        = out_motion_q;
  assign out_o.turn_degrees  = out_deg_q;
  assign out_o.table_changed = out_chg_q;
  assign out_o.last          = out_last_q;

  // Checks
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttpl_pkg::ST_INIT |-> !in_i.ready)
    else $error("word accepted during table clearing pass");

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("second word accepted before the first finished");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ttpl_pkg::ST_INIT || state_q == ttpl_pkg::ST_RWRITE))
    else $error("table written outside sweep or reward");

  a_angle_on_turn_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_motion_q != ttpl_pkg::MOT_TURN) |-> out_deg_q == '0)
    else $error("nonzero angle on a result that is not a turn step");

  a_change_on_reward_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_chg_q) |-> (out_motion_q == ttpl_pkg::MOT_STAND && out_last_q))
    else $error("table change flag on a result that is not the reward");

endmodule

FILE: tb/tb_tabular_turn_policy_learner_unit.sv
`timescale 1ns / 1ps
// Testbench of the learner: scripted and random sensor words checked against a turn predictor.
module tb_tabular_turn_policy_learner_unit;

  localparam int CELLS        = ttpl_pkg::BINS_PER_SENSOR * ttpl_pkg::BINS_PER_SENSOR;
  localparam int DEPTH        = ttpl_pkg::ACTIONS * CELLS;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 200;
  localparam int TAIL_WORDS   = 40;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AFTER   = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 60;

  typedef struct packed {
    logic                         clear;
    logic [ttpl_pkg::RANGE_W-1:0] left;
    logic [ttpl_pkg::RANGE_W-1:0] right;
  } sensor_word_t;

  typedef struct packed {
    ttpl_pkg::motion_e motion;
    ttpl_pkg::value_t  degrees;
    logic              changed;
    logic              last;
  } move_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // Channels and block
  ttpl_in_if  in_bus ();
  ttpl_out_if out_bus ();

  tabular_turn_policy_learner_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  logic         drv_valid  = 1'b0;
  sensor_word_t drv_word   = '0;
  logic         sink_ready = 1'b0;

  assign in_bus.valid          = drv_valid;
  assign in_bus.obstacle_clear = drv_word.clear;
  assign in_bus.range_left     = drv_word.left;
  assign in_bus.range_right    = drv_word.right;
  assign out_bus.ready         = sink_ready;

  // Predictor state: value table, phase and the entry picked in the turn phase
  int               q_table [DEPTH];
  ttpl_pkg::phase_e learn_phase;
  int               pick_cell;
  int               pick_action;

  sensor_word_t pending_words [$];
  move_t        expected_moves [$];
  int           error_count  = 0;
  int           results_seen = 0;
  int           cycle_count  = 0;
  logic         quiet_tail   = 1'b0;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int range_bin(input logic [ttpl_pkg::RANGE_W-1:0] r);
    int v;
    v = int'(r);
    if (v >= ttpl_pkg::RANGE_HIGH) return ttpl_pkg::BINS_PER_SENSOR - 1;
    if (v <= ttpl_pkg::RANGE_LOW) return 0;
    return (v - ttpl_pkg::RANGE_LOW) * ttpl_pkg::BINS_PER_SENSOR / ttpl_pkg::RANGE_SPAN;
  endfunction

  // Range inside a given bin; negative bin means anywhere in the sensor span
  function automatic logic [ttpl_pkg::RANGE_W-1:0] pick_range(input int bin);
    if (bin < 0) return ttpl_pkg::RANGE_W'($urandom_range(0, 600));
    if (bin == 0) return ttpl_pkg::RANGE_W'($urandom_range(0, ttpl_pkg::RANGE_LOW + 9));
    if (bin == ttpl_pkg::BINS_PER_SENSOR - 1)
      return ttpl_pkg::RANGE_W'($urandom_range(ttpl_pkg::RANGE_HIGH - 10, 600));
    return ttpl_pkg::RANGE_W'(ttpl_pkg::RANGE_LOW + 10 * bin + $urandom_range(0, 9));
  endfunction

  // Expected motions of one accepted sensor word
  task automatic predict_moves(input sensor_word_t w);
    move_t mv [ttpl_pkg::RESULT_CAP];
    int    n, cell_idx, best, act, d, v, idx;
    logic  obstacle;
    n = 0;
    obstacle = !w.clear;
    case (learn_phase)
      ttpl_pkg::PH_TURN: begin
        cell_idx = range_bin(w.left) * ttpl_pkg::BINS_PER_SENSOR + range_bin(w.right);
        best = ttpl_pkg::VALUE_FLOOR;
        act  = 0;
        for (int a = 0; a < ttpl_pkg::ACTIONS; a++) begin
          if (q_table[a * CELLS + cell_idx] > best) begin
            best = q_table[a * CELLS + cell_idx];
            act  = a;
          end
        end
        pick_cell   = cell_idx;
        pick_action = act;
        d = best;
        // full steps first, the last step carries what is left
        if (d > 0) begin
          while (d > ttpl_pkg::TURN_STEP && n < ttpl_pkg::RESULT_CAP - 1) begin
            mv[n] = '{ttpl_pkg::MOT_TURN, ttpl_pkg::value_t'(ttpl_pkg::TURN_STEP), 1'b0, 1'b0};
            n++;
            d -= ttpl_pkg::TURN_STEP;
          end
        end else begin
          while (d < -ttpl_pkg::TURN_STEP && n < ttpl_pkg::RESULT_CAP - 1) begin
            mv[n] = '{ttpl_pkg::MOT_TURN, ttpl_pkg::value_t'(-ttpl_pkg::TURN_STEP), 1'b0, 1'b0};
            n++;
            d += ttpl_pkg::TURN_STEP;
          end
        end
        mv[n] = '{ttpl_pkg::MOT_TURN, ttpl_pkg::value_t'(d), 1'b0, 1'b0};
        n++;
        learn_phase = ttpl_pkg::PH_REWARD;
      end
      ttpl_pkg::PH_REWARD: begin
        mv[0] = '{ttpl_pkg::MOT_STAND, ttpl_pkg::value_t'(0), 1'b0, 1'b0};
        if (obstacle) begin
          idx = pick_action * CELLS + pick_cell;
          v = 10 * q_table[idx] / 8;
          if (v > ttpl_pkg::VALUE_LIMIT || v < -ttpl_pkg::VALUE_LIMIT
              || (v < ttpl_pkg::SMALL_LIMIT && v > -ttpl_pkg::SMALL_LIMIT))
            v = ttpl_pkg::VALUE_DISCARD;
          q_table[idx] = v;
          mv[0].changed = 1'b1;
        end
        n = 1;
        learn_phase = ttpl_pkg::PH_WALK;
      end
      default: begin
        mv[0] = '{(obstacle ? ttpl_pkg::MOT_WALK_STAND : ttpl_pkg::MOT_WALK),
                  ttpl_pkg::value_t'(0), 1'b0, 1'b0};
        n = 1;
        learn_phase = obstacle ? ttpl_pkg::PH_TURN : ttpl_pkg::PH_WALK;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      mv[i].last = (i == n - 1);
      expected_moves.push_back(mv[i]);
    end
  endtask

  task automatic push_word(input logic clear, input logic [ttpl_pkg::RANGE_W-1:0] l,
                           input logic [ttpl_pkg::RANGE_W-1:0] r);
    pending_words.push_back(sensor_word_t'{clear, l, r});
  endtask

  // Walk with obstacle, turn on the given ranges, then reward
  task automatic push_triple(input logic [ttpl_pkg::RANGE_W-1:0] l,
                             input logic [ttpl_pkg::RANGE_W-1:0] r,
                             input logic reward_clear);
    push_word(1'b0, pick_range(-1), pick_range(-1));
    push_word(1'($urandom_range(0, 1)), l, r);
    push_word(reward_clear, pick_range(-1), pick_range(-1));
  endtask

  // Driver: offers pending words with random gaps, predicts on acceptance
  int drv_idle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_word   <= '0;
      drv_idle   <= 0;
      quiet_tail <= 1'b0;
    end else begin
      quiet_tail <= (pending_words.size() < TAIL_WORDS);
      if (drv_valid && in_bus.ready) predict_moves(drv_word);
      if (!drv_valid || in_bus.ready) begin
        if (drv_idle != 0) begin
          drv_idle  <= drv_idle - 1;
          drv_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          drv_idle  <= $urandom_range(0, 6);
          drv_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          drv_word  <= pending_words.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once enough results have come
  int   hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each accepted result word against the oldest expectation
  int sink_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    move_t exp_mv;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_bus.valid && sink_ready) begin
        results_seen <= results_seen + 1;
        if (expected_moves.size() == 0) begin
          report_mismatch($sformatf("unexpected result motion=%0d deg=%0d",
                                    out_bus.motion, out_bus.turn_degrees));
        end else begin
          exp_mv = expected_moves.pop_front();
          if (out_bus.motion !== exp_mv.motion)
            report_mismatch($sformatf("motion %0d, expected %0d",
                                      out_bus.motion, exp_mv.motion));
          if (out_bus.turn_degrees !== exp_mv.degrees)
            report_mismatch($sformatf("turn_degrees %0d, expected %0d",
                                      out_bus.turn_degrees, exp_mv.degrees));
          if (out_bus.table_changed !== exp_mv.changed)
            report_mismatch($sformatf("table_changed %0b, expected %0b",
                                      out_bus.table_changed, exp_mv.changed));
          if (out_bus.last !== exp_mv.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_bus.last, exp_mv.last));
        end
      end
      if (hold_left != 0) begin
        sink_ready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        sink_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        sink_stall <= $urandom_range(0, 6);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int made, pick, bl, br;
    for (int a = 0; a < ttpl_pkg::ACTIONS; a++)
      for (int c = 0; c < CELLS; c++)
        q_table[a * CELLS + c] = ttpl_pkg::INIT_LOW
                                 + ttpl_pkg::INIT_SPAN * a / (ttpl_pkg::ACTIONS - 1);
    learn_phase = ttpl_pkg::PH_WALK;
    pick_cell   = 0;
    pick_action = 0;

    // Directed: plain walk, repeated rewards on the lowest cell, clamp edges,
    // reward without obstacle
    push_word(1'b1, 10'd0, 10'd600);
    push_triple(10'd0, 10'd30, 1'b0);
    push_triple(10'd39, 10'd0, 1'b0);
    push_triple(10'd30, 10'd31, 1'b0);
    push_triple(10'd0, 10'd0, 1'b0);
    push_triple(10'd600, 10'd130, 1'b1);
    push_triple(10'd129, 10'd40, 1'b0);
    push_triple(10'd31, 10'd39, 1'b0);
    push_word(1'b1, 10'd600, 10'd0);

    // Random: mostly full loops on two hot cells, some noise words
    made = 0;
    while (made < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        push_word(1'($urandom_range(0, 3) != 0), pick_range(-1), pick_range(-1));
        made++;
      end else begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          bl = 0;
          br = 0;
        end else if (pick == 1) begin
          bl = ttpl_pkg::BINS_PER_SENSOR - 1;
          br = ttpl_pkg::BINS_PER_SENSOR - 1;
        end else if ($urandom_range(0, 1) == 0) begin
          bl = $urandom_range(0, ttpl_pkg::BINS_PER_SENSOR - 1);
          br = $urandom_range(0, ttpl_pkg::BINS_PER_SENSOR - 1);
        end else begin
          bl = -1;
          br = -1;
        end
        push_triple(pick_range(bl), pick_range(br), 1'($urandom_range(0, 4) == 0));
        made += 3;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
